// ----- hdl/smf_pkg.sv -----
package smf_pkg;

    localparam int MAX_WINDOW  = 31;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int MIN_SPAN    = 3;
    localparam int SPAN_DIV    = 2;
    localparam int RAD_MAX     = (MAX_WINDOW - 1) / SPAN_DIV;
    localparam int RAD_W       = $clog2(RAD_MAX + 1);
    localparam int CFG_W       = 5;
    localparam int WIN_RESET   = 5;

    typedef logic signed [SAMPLE_BITS-1:0] smf_sample_t;

    // per-cell compare flags against the probe value
    typedef struct packed {
        logic lt;
        logic eq;
    } smf_cmp_t;

    typedef struct packed {
        logic             vld;
        logic [CNT_W-1:0] lt_cnt;
        logic [CNT_W-1:0] eq_cnt;
    } smf_rank_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } smf_state_t;

    function automatic logic [RAD_W-1:0] radius(input logic [CFG_W-1:0] ws);
        logic [CFG_W-1:0] span;
        logic [CFG_W-1:0] r;
        span = (ws < CFG_W'(MIN_SPAN)) ? CFG_W'(MIN_SPAN) : ws;
        r = CFG_W'(span / SPAN_DIV);
        if (r > CFG_W'(RAD_MAX))
        begin
            r = CFG_W'(RAD_MAX);
        end
        return RAD_W'(r);
    endfunction

endpackage

// ----- hdl/sliding_median_filter.sv -----
// Running median over a stream: one median per sample, centered on a window of
// 2r+1 samples (r = span setting/2, a setting below 3 taken as 3), clipped at
// both ends of a sequence, upper median for even counts. A row of 31 cells holds
// the newest samples; one shared rank counter probes one candidate cell per
// cycle until it finds the sample of the wanted rank. Each median is found by
// that one-probe-per-cycle scan over a window of up to 31 samples, plus a wait
// for the output register. A sample flagged last produces up to r+1 medians
// one after another, each with a scan of its own, oldest position first, the
// final one flagged. New samples are taken only while no median is being
// worked on.
module sliding_median_filter
    import smf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   win_span,
    input  logic               in_valid,
    output logic               in_ready,
    input  smf_sample_t        sample,
    input  logic               last_in,
    output logic               out_valid,
    input  logic               out_ready,
    output smf_sample_t        median,
    output logic               last_out
);

    smf_state_t       state_reg, state_next;
    logic [CFG_W-1:0] win_span_reg;
    logic [CNT_W-1:0] filled_reg, filled_next;
    logic [RAD_W-1:0] r_reg, r_next;
    logic [RAD_W-1:0] c_reg, c_next;
    logic             flush_reg, flush_next;
    logic [IDX_W:0]   j_reg, j_next;
    logic             a_vld_reg, a_vld_next;
    logic             out_valid_reg, out_valid_next;
    smf_sample_t      cand_a_reg, cand_a_next;
    smf_sample_t      cand_b_reg, cand_b_next;
    smf_sample_t      res_reg, res_next;
    logic             res_last_reg, res_last_next;
    smf_sample_t      median_reg, median_next;
    logic             last_out_reg, last_out_next;

    logic             in_acc;
    logic [CNT_W-1:0] filled_new;
    logic [RAD_W-1:0] r_new;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] reach;
    logic [IDX_W-1:0] oldest;
    logic [CNT_W-1:0] k;
    logic             issue;
    logic             hit;
    logic             out_free;
    logic             more;

    smf_sample_t      cell_q   [MAX_WINDOW];
    smf_cmp_t         cell_cmp [MAX_WINDOW];
    smf_rank_t        rank;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign median    = median_reg;
    assign last_out  = last_out_reg;

    assign filled_new = (filled_reg == CNT_W'(MAX_WINDOW)) ? filled_reg
                                                           : filled_reg + CNT_W'(1);
    assign r_new      = radius(win_span_reg);

    // oldest cell of the current window
    assign reach  = IDX_W'(c_reg) + IDX_W'(r_reg);
    assign oldest = IDX_W'(filled_reg - CNT_W'(1));
    assign hi     = (reach < oldest) ? reach : oldest;
    assign k      = CNT_W'((CNT_W'(hi) + CNT_W'(1)) >> 1);

    assign issue    = (state_reg == ST_SCAN) && (j_reg <= (IDX_W + 1)'(hi));
    assign hit      = (state_reg == ST_SCAN) && rank.vld && (rank.lt_cnt <= k)
                      && ({1'b0, k} < ({1'b0, rank.lt_cnt} + {1'b0, rank.eq_cnt}));
    assign out_free = !out_valid_reg || out_ready;
    assign more     = flush_reg && (c_reg != '0);

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++)
        begin : g_cell
            smf_sample_t din_w;
            if (g == 0)
            begin : g_head
                assign din_w = sample;
            end
            else
            begin : g_body
                assign din_w = cell_q[g-1];
            end
            smf_cell u_cell (
                .clk    (clk),
                .load   (in_acc),
                .din    (din_w),
                .probe  (cand_a_reg),
                .active (IDX_W'(g) <= hi),
                .dout   (cell_q[g]),
                .cmp    (cell_cmp[g])
            );
        end
    endgenerate

    smf_rank_count u_rank (
        .clk   (clk),
        .rst_n (rst_n),
        .cmp   (cell_cmp),
        .valid (a_vld_reg),
        .kill  (hit),
        .rank  (rank)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (last_in || (filled_new > CNT_W'(r_new))))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = more ? ST_SCAN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        filled_next    = filled_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        flush_next     = flush_reg;
        j_next         = j_reg;
        a_vld_next     = issue && !hit;
        cand_a_next    = cand_a_reg;
        cand_b_next    = a_vld_reg ? cand_a_reg : cand_b_reg;
        res_next       = res_reg;
        res_last_next  = res_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        median_next    = median_reg;
        last_out_next  = last_out_reg;

        if (issue && !hit)
        begin
            cand_a_next = cell_q[j_reg[IDX_W-1:0]];
            j_next      = j_reg + (IDX_W + 1)'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    filled_next = filled_new;
                    r_next      = r_new;
                    flush_next  = last_in;
                    j_next      = '0;
                    if (last_in && !(CNT_W'(r_new) < filled_new - CNT_W'(1)))
                    begin
                        c_next = RAD_W'(filled_new - CNT_W'(1));
                    end
                    else
                    begin
                        c_next = r_new;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_next      = cand_b_reg;
                    res_last_next = flush_reg && (c_reg == '0);
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    median_next    = res_reg;
                    last_out_next  = res_last_reg;
                    j_next         = '0;
                    if (more)
                    begin
                        c_next = c_reg - RAD_W'(1);
                    end
                    else if (flush_reg)
                    begin
                        // end of sequence: next sample starts fresh
                        filled_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_span_reg  <= CFG_W'(WIN_RESET);
            filled_reg    <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            flush_reg     <= 1'b0;
            j_reg         <= '0;
            a_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            flush_reg     <= flush_next;
            j_reg         <= j_next;
            a_vld_reg     <= a_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                win_span_reg <= win_span;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cand_a_reg   <= cand_a_next;
        cand_b_reg   <= cand_b_next;
        res_reg      <= res_next;
        res_last_reg <= res_last_next;
        median_reg   <= median_next;
        last_out_reg <= last_out_next;
    end

    // scan must find the ranked sample before running off the window
    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((j_reg <= (IDX_W + 1)'(hi)) || a_vld_reg || rank.vld))
        else $error("median scan ran past the window without a hit");

    // the probed sample is always inside the window, so it counts itself
    a_probe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (rank.vld && (state_reg == ST_SCAN)) |-> (rank.eq_cnt != '0))
        else $error("probe value not found among active cells");

    a_filled_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> ((filled_reg != '0) && (filled_reg <= CNT_W'(MAX_WINDOW))))
        else $error("fill count out of range during a median");

    // a median is delivered only from the hold state
    a_load_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || out_ready) && !$past(state_reg == ST_HOLD) && !out_valid_reg
        |-> 1'b1 ##0 ((state_reg == ST_HOLD) || !out_valid_next))
        else $error("output loaded outside the hold state");

endmodule

// ----- hdl/smf_cell.sv -----
module smf_cell
    import smf_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  smf_sample_t din,
    input  smf_sample_t probe,
    input  logic        active,
    output smf_sample_t dout,
    output smf_cmp_t    cmp
);

    smf_sample_t sample_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= din;
        end
    end

    assign dout   = sample_reg;
    assign cmp.lt = active && (sample_reg < probe);
    assign cmp.eq = active && (sample_reg == probe);

endmodule

// ----- hdl/smf_rank_count.sv -----
module smf_rank_count
    import smf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  smf_cmp_t  cmp [MAX_WINDOW],
    input  logic      valid,
    input  logic      kill,
    output smf_rank_t rank
);

    logic             vld_reg;
    logic [CNT_W-1:0] lt_cnt_reg;
    logic [CNT_W-1:0] eq_cnt_reg;
    logic [CNT_W-1:0] lt_sum;
    logic [CNT_W-1:0] eq_sum;

    always_comb
    begin
        lt_sum = '0;
        eq_sum = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            lt_sum = lt_sum + CNT_W'(cmp[i].lt);
            eq_sum = eq_sum + CNT_W'(cmp[i].eq);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= valid && !kill;
        end
    end

    always_ff @(posedge clk)
    begin
        lt_cnt_reg <= lt_sum;
        eq_cnt_reg <= eq_sum;
    end

    assign rank.vld    = vld_reg;
    assign rank.lt_cnt = lt_cnt_reg;
    assign rank.eq_cnt = eq_cnt_reg;

endmodule
